// ----- design/i2cms_pkg.sv -----
// shared types and constants of the i2c master byte sequencer
package i2cms_pkg;

	localparam int UNIT_W  = 12;
	localparam int WAIT_W  = 16;
	localparam int PHASE_W = 5;
	localparam int BCNT_W  = 4;
	localparam int KIND_W  = 3;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// command codes
	localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_START = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

	// register indexes
	localparam logic [PADDR_W-3:0] REG_UNIT_TICKS = 1'b0;

	localparam logic [UNIT_W-1:0] UNIT_TICKS_RST = 12'd1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [7:0]        data_byte;
		logic              send_ack;
		logic              sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_received;
	} res_t;

endpackage

// ----- design/i2cms_cfg.sv -----
// apb register file holding the delay unit length
module i2cms_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [i2cms_pkg::PADDR_W-1:0]   paddr,
	input  logic [i2cms_pkg::PDATA_W-1:0]   pwdata,
	output logic [i2cms_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready,
	output logic [i2cms_pkg::UNIT_W-1:0]    unit_ticks
);

	logic [i2cms_pkg::UNIT_W-1:0] unit_ticks_q;
	logic                         hit;

	assign pready = 1'b1;
	assign hit    = (paddr[i2cms_pkg::PADDR_W-1:2] == i2cms_pkg::REG_UNIT_TICKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= i2cms_pkg::UNIT_TICKS_RST;
		end else if (psel && penable && pwrite && pready && hit) begin
			unit_ticks_q <= pwdata[i2cms_pkg::UNIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata[i2cms_pkg::UNIT_W-1:0] = unit_ticks_q;
		end
	end

	assign unit_ticks = unit_ticks_q;

endmodule

// ----- design/i2cms_seq.sv -----
// bus phase sequencer: state registers and one-tick next-state logic
module i2cms_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  i2cms_pkg::item_t             item,
	input  logic [i2cms_pkg::UNIT_W-1:0] unit_ticks,
	output i2cms_pkg::res_t              res
);

	localparam logic [4:0] P_IDLE       = 5'd0;
	localparam logic [4:0] P_ST_SDA_HI  = 5'd1;
	localparam logic [4:0] P_ST_SCL_HI  = 5'd2;
	localparam logic [4:0] P_ST_SDA_LO  = 5'd3;
	localparam logic [4:0] P_ST_SCL_LO  = 5'd4;
	localparam logic [4:0] P_SP_SDA_LO  = 5'd5;
	localparam logic [4:0] P_SP_SCL_HI  = 5'd6;
	localparam logic [4:0] P_SP_SDA_HI  = 5'd7;
	localparam logic [4:0] P_WR_BIT     = 5'd8;
	localparam logic [4:0] P_WR_SCL_HI  = 5'd9;
	localparam logic [4:0] P_WR_SCL_LO  = 5'd10;
	localparam logic [4:0] P_WR_REL     = 5'd11;
	localparam logic [4:0] P_WR_ACK_HI  = 5'd12;
	localparam logic [4:0] P_WR_SAMPLE  = 5'd13;
	localparam logic [4:0] P_WR_ACK_LO  = 5'd14;
	localparam logic [4:0] P_RD_REL     = 5'd15;
	localparam logic [4:0] P_RD_SCL_HI  = 5'd16;
	localparam logic [4:0] P_RD_SAMPLE  = 5'd17;
	localparam logic [4:0] P_RD_ACK     = 5'd18;
	localparam logic [4:0] P_RD_SCL_HI2 = 5'd19;
	localparam logic [4:0] P_RD_SCL_LO2 = 5'd20;
	localparam logic [4:0] P_FINISH     = 5'd21;

	localparam int WW = i2cms_pkg::WAIT_W;
	localparam int BW = i2cms_pkg::BCNT_W;

	logic [4:0]    phase_q, phase_d;
	logic [BW-1:0] bcnt_q, bcnt_d;
	logic [7:0]    shift_q, shift_d;
	logic [WW-1:0] wait_q, wait_d;
	logic          scl_q, scl_d;
	logic          sda_q, sda_d;
	logic          ack_flag_q, ack_flag_d;
	logic          ack_req_q, ack_req_d;
	logic [7:0]    read_q, read_d;
	logic          done_d;

	logic                         do_act;
	logic [2:0]                   units;
	logic [4:0]                   next_ph;
	logic                         act_valid;
	logic [i2cms_pkg::UNIT_W-1:0] unit_len;
	logic [WW-1:0]                wait_load;
	logic [BW-1:0]                bcnt_inc;

	// zero length counts as one tick per unit
	assign unit_len  = (unit_ticks == '0) ? i2cms_pkg::UNIT_W'(1) : unit_ticks;
	assign wait_load = WW'(units) * WW'(unit_len) - WW'(1);

	always_comb begin
		phase_d    = phase_q;
		bcnt_d     = bcnt_q;
		shift_d    = shift_q;
		wait_d     = wait_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		ack_flag_d = ack_flag_q;
		ack_req_d  = ack_req_q;
		read_d     = read_q;
		done_d     = 1'b0;
		do_act     = 1'b0;

		// launch, count down, finish or next action
		if (phase_q == P_IDLE || phase_q > P_FINISH) begin
			phase_d = P_IDLE;
			bcnt_d  = '0;
			case (item.kind)
				i2cms_pkg::KIND_START: begin
					phase_d = P_ST_SDA_HI;
				end
				i2cms_pkg::KIND_STOP: begin
					phase_d = P_SP_SDA_LO;
				end
				i2cms_pkg::KIND_WRITE: begin
					shift_d = item.data_byte;
					phase_d = P_WR_BIT;
				end
				i2cms_pkg::KIND_READ: begin
					shift_d   = '0;
					ack_req_d = item.send_ack;
					phase_d   = P_RD_REL;
				end
				default: begin
					phase_d = P_IDLE;
				end
			endcase
			do_act = (phase_d != P_IDLE);
		end else if (wait_q != '0) begin
			wait_d = wait_q - WW'(1);
		end else if (phase_q == P_FINISH) begin
			phase_d = P_IDLE;
			done_d  = 1'b1;
		end else begin
			do_act = 1'b1;
		end

		// line action of the phase now current
		units     = 3'd0;
		next_ph   = P_FINISH;
		act_valid = 1'b1;
		bcnt_inc  = bcnt_d + BW'(1);
		if (do_act) begin
			case (phase_d)
				P_ST_SDA_HI: begin sda_d = 1'b1; units = 3'd4; next_ph = P_ST_SCL_HI; end
				P_ST_SCL_HI: begin scl_d = 1'b1; units = 3'd4; next_ph = P_ST_SDA_LO; end
				P_ST_SDA_LO: begin sda_d = 1'b0; units = 3'd4; next_ph = P_ST_SCL_LO; end
				P_ST_SCL_LO: begin scl_d = 1'b0; units = 3'd4; next_ph = P_FINISH; end
				P_SP_SDA_LO: begin sda_d = 1'b0; units = 3'd4; next_ph = P_SP_SCL_HI; end
				P_SP_SCL_HI: begin scl_d = 1'b1; units = 3'd4; next_ph = P_SP_SDA_HI; end
				P_SP_SDA_HI: begin sda_d = 1'b1; units = 3'd4; next_ph = P_FINISH; end
				P_WR_BIT: begin
					sda_d   = shift_d[7];
					units   = 3'd3;
					next_ph = P_WR_SCL_HI;
				end
				P_WR_SCL_HI: begin scl_d = 1'b1; units = 3'd5; next_ph = P_WR_SCL_LO; end
				P_WR_SCL_LO: begin
					scl_d   = 1'b0;
					shift_d = {shift_d[6:0], 1'b0};
					bcnt_d  = bcnt_inc;
					units   = 3'd2;
					next_ph = (bcnt_inc >= BW'(8)) ? P_WR_REL : P_WR_BIT;
				end
				P_WR_REL:    begin sda_d = 1'b1; units = 3'd3; next_ph = P_WR_ACK_HI; end
				P_WR_ACK_HI: begin scl_d = 1'b1; units = 3'd3; next_ph = P_WR_SAMPLE; end
				P_WR_SAMPLE: begin
					ack_flag_d = ~item.sda_in;
					units      = 3'd2;
					next_ph    = P_WR_ACK_LO;
				end
				P_WR_ACK_LO: begin scl_d = 1'b0; units = 3'd2; next_ph = P_FINISH; end
				P_RD_REL:    begin sda_d = 1'b1; units = 3'd3; next_ph = P_RD_SCL_HI; end
				P_RD_SCL_HI: begin scl_d = 1'b1; units = 3'd4; next_ph = P_RD_SAMPLE; end
				P_RD_SAMPLE: begin
					shift_d = {shift_d[6:0], item.sda_in};
					scl_d   = 1'b0;
					bcnt_d  = bcnt_inc;
					units   = 3'd2;
					next_ph = (bcnt_inc >= BW'(8)) ? P_RD_ACK : P_RD_SCL_HI;
				end
				P_RD_ACK: begin
					sda_d   = ~ack_req_d;
					read_d  = shift_d;
					units   = 3'd3;
					next_ph = P_RD_SCL_HI2;
				end
				P_RD_SCL_HI2: begin scl_d = 1'b1; units = 3'd5; next_ph = P_RD_SCL_LO2; end
				P_RD_SCL_LO2: begin scl_d = 1'b0; units = 3'd2; next_ph = P_FINISH; end
				default: begin
					act_valid = 1'b0;
				end
			endcase
			if (act_valid) begin
				phase_d = next_ph;
				wait_d  = wait_load;
			end else begin
				phase_d = P_IDLE;
				wait_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= P_IDLE;
			bcnt_q     <= '0;
			shift_q    <= '0;
			wait_q     <= '0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			ack_flag_q <= 1'b0;
			ack_req_q  <= 1'b0;
			read_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			bcnt_q     <= bcnt_d;
			shift_q    <= shift_d;
			wait_q     <= wait_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
			ack_flag_q <= ack_flag_d;
			ack_req_q  <= ack_req_d;
			read_q     <= read_d;
		end
	end

	assign res.scl_out      = scl_d;
	assign res.sda_out      = sda_d;
	assign res.busy_res     = (phase_d != P_IDLE);
	assign res.done_res     = done_d;
	assign res.read_data    = read_d;
	assign res.ack_received = ack_flag_d;

endmodule

// ----- design/i2c_master_byte_sequencer.sv -----
// top level of the i2c master byte sequencer
//
// usage
// - every input transfer is one timing tick; kind may carry a command
//   (start, stop, write byte, read byte) which is taken only while idle
// - every accepted tick yields exactly one result transfer: scl and sda
//   drive levels (1 released), busy, a one-tick done pulse, the last read
//   byte and the last write acknowledge
// - unit_ticks at byte address 0 sets ticks per delay unit (0 acts as 1);
//   write it only while the sequencer is idle
// - result path: the input register, then the result register
// - throughput: one tick per clock while the output is not stalled; the input
//   register feeds the next-state logic and the result register directly
// - output stall holds the result register while it is valid; a tick in the
//   input register then waits and in_stall rises, so no tick is lost
// - reset: lines released, idle, unit length one, both registers empty
module i2c_master_byte_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	// apb configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [i2cms_pkg::PADDR_W-1:0]     paddr,
	input  logic [i2cms_pkg::PDATA_W-1:0]     pwdata,
	output logic [i2cms_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready,
	// tick channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [i2cms_pkg::KIND_W-1:0]      kind,
	input  logic [7:0]                        data_byte,
	input  logic                              send_ack,
	input  logic                              sda_in,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              scl_out,
	output logic                              sda_out,
	output logic                              busy_res,
	output logic                              done_res,
	output logic [7:0]                        read_data,
	output logic                              ack_received
);

	logic [i2cms_pkg::UNIT_W-1:0] unit_ticks;
	i2cms_pkg::item_t             item_s1;
	logic                         valid_s1;
	i2cms_pkg::res_t              res_next;
	i2cms_pkg::res_t              res_s2;
	logic                         valid_s2;
	logic                         advance;
	logic                         in_xfer;

	// stage 1 moves into the result register when that is free or drained
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	i2cms_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.unit_ticks (unit_ticks)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.kind      <= kind;
			item_s1.data_byte <= data_byte;
			item_s1.send_ack  <= send_ack;
			item_s1.sda_in    <= sda_in;
		end
	end

	// sequencer state advances once per tick that reaches the result register
	i2cms_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.unit_ticks (unit_ticks),
		.res        (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid    = valid_s2;
	assign scl_out      = res_s2.scl_out;
	assign sda_out      = res_s2.sda_out;
	assign busy_res     = res_s2.busy_res;
	assign done_res     = res_s2.done_res;
	assign read_data    = res_s2.read_data;
	assign ack_received = res_s2.ack_received;

endmodule

// ----- sim/tb_top.sv -----
// testbench of the i2c master byte sequencer: command sequences checked tick by tick
module tb_top;

	localparam int WDOG_LIMIT  = 2000;
	localparam int RAND_TICKS  = 450;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_PRINTS  = 30;

	localparam int KW = i2cms_pkg::KIND_W;
	localparam int AW = i2cms_pkg::PADDR_W;
	localparam int DW = i2cms_pkg::PDATA_W;
	localparam int UW = i2cms_pkg::UNIT_W;
	localparam int WW = i2cms_pkg::WAIT_W;

	// out-of-range command codes, taken as tick only
	localparam logic [KW-1:0] KIND_BAD_LO = 3'd5;
	localparam logic [KW-1:0] KIND_BAD_HI = 3'd7;

	localparam logic [AW-1:0] UNIT_ADDR = {i2cms_pkg::REG_UNIT_TICKS, 2'b00};
	localparam logic [UW-1:0] UNIT_MAX  = '1;

	// line action steps of the sequencer
	typedef enum logic [4:0] {
		SQ_IDLE,
		SQ_ST_SDA_HI, SQ_ST_SCL_HI, SQ_ST_SDA_LO, SQ_ST_SCL_LO,
		SQ_SP_SDA_LO, SQ_SP_SCL_HI, SQ_SP_SDA_HI,
		SQ_WR_BIT, SQ_WR_SCL_HI, SQ_WR_SCL_LO, SQ_WR_REL,
		SQ_WR_ACK_HI, SQ_WR_SAMPLE, SQ_WR_ACK_LO,
		SQ_RD_REL, SQ_RD_SCL_HI, SQ_RD_SAMPLE, SQ_RD_ACK,
		SQ_RD_SCL_HI2, SQ_RD_SCL_LO2,
		SQ_FINISH
	} seq_step_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b1;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [AW-1:0]       paddr     = '0;
	logic [DW-1:0]       pwdata    = '0;
	logic [DW-1:0]       prdata;
	logic                pready;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [KW-1:0]       kind      = i2cms_pkg::KIND_TICK;
	logic [7:0]          data_byte = '0;
	logic                send_ack  = 1'b0;
	logic                sda_in    = 1'b1;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                scl_out;
	logic                sda_out;
	logic                busy_res;
	logic                done_res;
	logic [7:0]          read_data;
	logic                ack_received;

	// bus sequencer image
	seq_step_t           seq_q;
	int unsigned         bits_done;
	logic [7:0]          shreg;
	logic [WW-1:0]       dly_left;
	logic                scl_lvl;
	logic                sda_lvl;
	logic                ack_seen;
	logic                ack_want;
	logic [7:0]          rd_byte;
	logic [UW-1:0]       unit_len;

	i2cms_pkg::res_t     line_res_q[$];
	i2cms_pkg::res_t     want;
	i2cms_pkg::res_t     got;
	int                  err_count  = 0;
	int                  ticks_sent = 0;
	int                  idle_cnt   = 0;
	int                  sda_force  = -1;
	bit                  tx_idle_on = 1'b0;
	bit                  rx_idle_on = 1'b0;
	int                  hold_ask   = 0;
	int                  hold_done  = 0;
	int                  hold_left  = 0;
	int                  stall_left = 0;

	i2c_master_byte_sequencer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.send_ack     (send_ack),
		.sda_in       (sda_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scl_out      (scl_out),
		.sda_out      (sda_out),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.read_data    (read_data),
		.ack_received (ack_received)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	task automatic reset_image();
		seq_q     = SQ_IDLE;
		bits_done = 0;
		shreg     = '0;
		dly_left  = '0;
		scl_lvl   = 1'b1;
		sda_lvl   = 1'b1;
		ack_seen  = 1'b0;
		ack_want  = 1'b0;
		rd_byte   = '0;
		unit_len  = i2cms_pkg::UNIT_TICKS_RST;
	endtask

	// runs the line action of the current step, then arms its wait
	function automatic void do_line_action(logic sda_smp);
		int unsigned units;
		int unsigned tpu;
		seq_step_t   nxt;
		units = 0;
		nxt   = SQ_FINISH;
		tpu   = (unit_len == '0) ? 1 : unit_len;
		case (seq_q)
		SQ_ST_SDA_HI: begin sda_lvl = 1'b1; units = 4; nxt = SQ_ST_SCL_HI; end
		SQ_ST_SCL_HI: begin scl_lvl = 1'b1; units = 4; nxt = SQ_ST_SDA_LO; end
		SQ_ST_SDA_LO: begin sda_lvl = 1'b0; units = 4; nxt = SQ_ST_SCL_LO; end
		SQ_ST_SCL_LO: begin scl_lvl = 1'b0; units = 4; nxt = SQ_FINISH; end
		SQ_SP_SDA_LO: begin sda_lvl = 1'b0; units = 4; nxt = SQ_SP_SCL_HI; end
		SQ_SP_SCL_HI: begin scl_lvl = 1'b1; units = 4; nxt = SQ_SP_SDA_HI; end
		SQ_SP_SDA_HI: begin sda_lvl = 1'b1; units = 4; nxt = SQ_FINISH; end
		SQ_WR_BIT: begin sda_lvl = shreg[7]; units = 3; nxt = SQ_WR_SCL_HI; end
		SQ_WR_SCL_HI: begin scl_lvl = 1'b1; units = 5; nxt = SQ_WR_SCL_LO; end
		SQ_WR_SCL_LO: begin
			scl_lvl   = 1'b0;
			shreg     = {shreg[6:0], 1'b0};
			bits_done = bits_done + 1;
			units     = 2;
			nxt       = (bits_done >= 8) ? SQ_WR_REL : SQ_WR_BIT;
		end
		SQ_WR_REL:    begin sda_lvl = 1'b1; units = 3; nxt = SQ_WR_ACK_HI; end
		SQ_WR_ACK_HI: begin scl_lvl = 1'b1; units = 3; nxt = SQ_WR_SAMPLE; end
		SQ_WR_SAMPLE: begin ack_seen = ~sda_smp; units = 2; nxt = SQ_WR_ACK_LO; end
		SQ_WR_ACK_LO: begin scl_lvl = 1'b0; units = 2; nxt = SQ_FINISH; end
		SQ_RD_REL:    begin sda_lvl = 1'b1; units = 3; nxt = SQ_RD_SCL_HI; end
		SQ_RD_SCL_HI: begin scl_lvl = 1'b1; units = 4; nxt = SQ_RD_SAMPLE; end
		SQ_RD_SAMPLE: begin
			shreg     = {shreg[6:0], sda_smp};
			scl_lvl   = 1'b0;
			bits_done = bits_done + 1;
			units     = 2;
			nxt       = (bits_done >= 8) ? SQ_RD_ACK : SQ_RD_SCL_HI;
		end
		SQ_RD_ACK: begin
			sda_lvl = ~ack_want;
			rd_byte = shreg;
			units   = 3;
			nxt     = SQ_RD_SCL_HI2;
		end
		SQ_RD_SCL_HI2: begin scl_lvl = 1'b1; units = 5; nxt = SQ_RD_SCL_LO2; end
		SQ_RD_SCL_LO2: begin scl_lvl = 1'b0; units = 2; nxt = SQ_FINISH; end
		default: begin
			seq_q    = SQ_IDLE;
			dly_left = '0;
			return;
		end
		endcase
		seq_q    = nxt;
		dly_left = WW'(units * tpu - 1);
	endfunction

	// one tick of the sequencer; commands are taken only while idle
	function automatic i2cms_pkg::res_t bus_tick(i2cms_pkg::item_t it);
		i2cms_pkg::res_t r;
		logic            fin;
		fin = 1'b0;
		if (seq_q == SQ_IDLE) begin
			bits_done = 0;
			case (it.kind)
			i2cms_pkg::KIND_START: seq_q = SQ_ST_SDA_HI;
			i2cms_pkg::KIND_STOP:  seq_q = SQ_SP_SDA_LO;
			i2cms_pkg::KIND_WRITE: begin
				shreg = it.data_byte;
				seq_q = SQ_WR_BIT;
			end
			i2cms_pkg::KIND_READ: begin
				shreg    = '0;
				ack_want = it.send_ack;
				seq_q    = SQ_RD_REL;
			end
			default: ;
			endcase
			if (seq_q != SQ_IDLE)
				do_line_action(it.sda_in);
		end else if (dly_left != '0) begin
			dly_left = dly_left - 1'b1;
		end else if (seq_q == SQ_FINISH) begin
			seq_q = SQ_IDLE;
			fin   = 1'b1;
		end else begin
			do_line_action(it.sda_in);
		end
		r.scl_out      = scl_lvl;
		r.sda_out      = sda_lvl;
		r.busy_res     = (seq_q != SQ_IDLE);
		r.done_res     = fin;
		r.read_data    = rd_byte;
		r.ack_received = ack_seen;
		return r;
	endfunction

	// ---------------------------------------------------------------- helpers

	task automatic report_mismatch(input string what, input int unsigned want_v,
			input int unsigned got_v);
		if (err_count < MAX_PRINTS)
			$display("mismatch %s: expected %0h got %0h (tick %0d)", what, want_v, got_v,
				ticks_sent);
		err_count++;
	endtask

	// idle stretch length: mostly short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [KW-1:0] pick_cmd();
		case ($urandom_range(0, 3))
		0:       return i2cms_pkg::KIND_START;
		1:       return i2cms_pkg::KIND_STOP;
		2:       return i2cms_pkg::KIND_WRITE;
		default: return i2cms_pkg::KIND_READ;
		endcase
	endfunction

	function automatic logic pick_sda();
		return (sda_force < 0) ? 1'($urandom()) : 1'(sda_force);
	endfunction

	// tick sent while a sequence runs; with junk set it also carries
	// commands that must be ignored, always on the done tick
	function automatic i2cms_pkg::item_t filler(bit junk);
		i2cms_pkg::item_t it;
		it.kind = i2cms_pkg::KIND_TICK;
		if (junk && seq_q == SQ_FINISH && dly_left == '0)
			it.kind = pick_cmd();
		else if (junk && $urandom_range(0, 3) == 0)
			it.kind = KW'($urandom_range(0, 2**KW - 1));
		it.data_byte = 8'($urandom());
		it.send_ack  = 1'($urandom());
		it.sda_in    = pick_sda();
		return it;
	endfunction

	// one tick transfer; the expected line state is queued on acceptance
	task automatic send_tick(input i2cms_pkg::item_t it);
		int gap;
		in_valid  <= 1'b1;
		kind      <= it.kind;
		data_byte <= it.data_byte;
		send_ack  <= it.send_ack;
		sda_in    <= it.sda_in;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		line_res_q.push_back(bus_tick(it));
		ticks_sent++;
		gap = (tx_idle_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue_cmd(input logic [KW-1:0] k, input logic [7:0] d,
			input logic sa);
		i2cms_pkg::item_t it;
		it.kind      = k;
		it.data_byte = d;
		it.send_ack  = sa;
		it.sda_in    = pick_sda();
		send_tick(it);
	endtask

	task automatic tick_until_idle(input bit junk);
		while (seq_q != SQ_IDLE)
			send_tick(filler(junk));
	endtask

	task automatic run_cmd(input logic [KW-1:0] k, input logic [7:0] d,
			input logic sa, input bit junk);
		issue_cmd(k, d, sa);
		tick_until_idle(junk);
	endtask

	// stop offering ticks and let every pending result come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (line_res_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// apb write of the unit length, then read it back
	task automatic set_unit(input logic [UW-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= UNIT_ADDR;
		pwdata  <= DW'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		unit_len = v;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[UW-1:0] !== v)
			report_mismatch("unit_ticks read-back", v, prdata[UW-1:0]);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// ---------------------------------------------------------------- receiver side

	// result stall: a requested long hold first, else random stretches
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_ask != hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			hold_done <= hold_ask;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
			out_stall  <= 1'b1;
			stall_left <= idle_len() - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// each result transfer is held against the oldest queued tick
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got.scl_out      = scl_out;
			got.sda_out      = sda_out;
			got.busy_res     = busy_res;
			got.done_res     = done_res;
			got.read_data    = read_data;
			got.ack_received = ack_received;
			if (line_res_q.size() == 0) begin
				report_mismatch("result with no pending tick", 0, 1);
			end else begin
				want = line_res_q.pop_front();
				if (got.scl_out !== want.scl_out)
					report_mismatch("scl_out", want.scl_out, got.scl_out);
				if (got.sda_out !== want.sda_out)
					report_mismatch("sda_out", want.sda_out, got.sda_out);
				if (got.busy_res !== want.busy_res)
					report_mismatch("busy_res", want.busy_res, got.busy_res);
				if (got.done_res !== want.done_res)
					report_mismatch("done_res", want.done_res, got.done_res);
				if (got.read_data !== want.read_data)
					report_mismatch("read_data", want.read_data, got.read_data);
				if (got.ack_received !== want.ack_received)
					report_mismatch("ack_received", want.ack_received, got.ack_received);
			end
		end
	end

	// watchdog: too long without any transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= WDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// every command at least once, field extremes, codes out of range, and
	// commands during a sequence and on its done tick
	task automatic test_directed();
		i2cms_pkg::item_t it;
		it = '0;
		send_tick(it);
		for (int k = KIND_BAD_LO; k <= KIND_BAD_HI; k++) begin
			it.kind      = KW'(k);
			it.data_byte = 8'hff;
			it.send_ack  = 1'b1;
			it.sda_in    = 1'b0;
			send_tick(it);
		end
		run_cmd(i2cms_pkg::KIND_START, 8'h00, 1'b0, 1'b1);
		sda_force = 0;
		run_cmd(i2cms_pkg::KIND_WRITE, 8'hff, 1'b0, 1'b1);
		sda_force = 1;
		run_cmd(i2cms_pkg::KIND_WRITE, 8'h00, 1'b1, 1'b1);
		sda_force = -1;
		run_cmd(i2cms_pkg::KIND_WRITE, 8'ha5, 1'b0, 1'b1);
		sda_force = 1;
		run_cmd(i2cms_pkg::KIND_READ, 8'h00, 1'b1, 1'b1);
		sda_force = 0;
		run_cmd(i2cms_pkg::KIND_READ, 8'hff, 1'b0, 1'b1);
		sda_force = -1;
		run_cmd(i2cms_pkg::KIND_STOP, 8'h00, 1'b0, 1'b1);
	endtask

	// unit length zero acts as one; a longer unit runs a stop;
	// the largest unit is written and read back
	task automatic test_unit_extremes();
		drain_results();
		set_unit('0);
		run_cmd(i2cms_pkg::KIND_START, 8'h00, 1'b0, 1'b1);
		drain_results();
		tx_idle_on = 1'b0;
		rx_idle_on <= 1'b0;
		set_unit(12'd7);
		run_cmd(i2cms_pkg::KIND_STOP, 8'h00, 1'($urandom()), 1'b1);
		drain_results();
		set_unit(UNIT_MAX);
		set_unit(i2cms_pkg::UNIT_TICKS_RST);
	endtask

	// mostly whole sequences with random content, some idle noise
	task automatic test_random_traffic();
		i2cms_pkg::item_t it;
		int               stop_at;
		int               mark;
		int               seq_ticks;
		seq_ticks = 0;
		while (seq_ticks < RAND_TICKS) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on <= ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0) begin
				drain_results();
				case ($urandom_range(0, 5))
				0:       set_unit('0);
				1:       set_unit(12'd2);
				2:       set_unit(12'd3);
				default: set_unit(i2cms_pkg::UNIT_TICKS_RST);
				endcase
			end
			if ($urandom_range(0, 99) < 85) begin
				mark = ticks_sent;
				run_cmd(pick_cmd(), 8'($urandom()), 1'($urandom()), 1'($urandom()));
				seq_ticks += ticks_sent - mark;
			end else begin
				stop_at = $urandom_range(1, 4);
				for (int n = 0; n < stop_at; n++) begin
					it.kind = ($urandom_range(0, 2) == 0) ? i2cms_pkg::KIND_TICK :
						KW'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
					it.data_byte = 8'($urandom());
					it.send_ack  = 1'($urandom());
					it.sda_in    = 1'($urandom());
					send_tick(it);
				end
			end
		end
		drain_results();
		set_unit(i2cms_pkg::UNIT_TICKS_RST);
	endtask

	// long result hold while ticks keep coming, then a full drain mid-sequence
	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		rx_idle_on <= 1'b0;
		issue_cmd(i2cms_pkg::KIND_WRITE, 8'($urandom()), 1'b0);
		hold_ask <= hold_ask + 1;
		tick_until_idle(1'b0);
		issue_cmd(i2cms_pkg::KIND_READ, 8'h00, 1'($urandom()));
		repeat (20) send_tick(filler(1'b1));
		drain_results();
		tx_idle_on = 1'b1;
		rx_idle_on <= 1'b1;
		tick_until_idle(1'b1);
	endtask

	initial begin
		reset_image();
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_unit_extremes();
		test_random_traffic();
		test_backpressure();

		drain_results();
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
design/i2cms_pkg.sv
design/i2cms_cfg.sv
design/i2cms_seq.sv
design/i2c_master_byte_sequencer.sv
sim/tb_top.sv
